[hdl/hv_precharge_safety_sequencer_defines.svh]
// Assertion macros shared by the sequencer RTL.
`ifndef HV_PRECHARGE_SAFETY_SEQUENCER_DEFINES_SVH
`define HV_PRECHARGE_SAFETY_SEQUENCER_DEFINES_SVH

// Check a property on the rising clock edge, skipped while reset is asserted.
`define HVPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on the rising clock edge, also during reset.
`define HVPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/hvps_pkg.sv]
// Types, constants and register map of the HV precharge safety sequencer.
`timescale 1ns / 1ps
package hvps_pkg;

    localparam int MV_W   = 13;
    localparam int TEMP_W = 12;
    localparam int CNT_W  = 16;
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    localparam logic [MV_W-1:0]          UNDERVOLT_RST  = 13'd2800;
    localparam logic [MV_W-1:0]          OVERVOLT_RST   = 13'd4300;
    localparam logic signed [TEMP_W-1:0] OVERTEMP_RST   = 12'sd600;
    localparam logic [CNT_W-1:0]         PRECHARGE_RST  = 16'd5000;

    localparam logic [MV_W-1:0]          RUN_MIN_RST  = 13'd8191;
    localparam logic [MV_W-1:0]          RUN_MAX_RST  = 13'd0;
    localparam logic signed [TEMP_W-1:0] RUN_TEMP_RST = -12'sd2048;

    localparam logic [1:0] REG_UNDERVOLT = 2'd0;
    localparam logic [1:0] REG_OVERVOLT  = 2'd1;
    localparam logic [1:0] REG_OVERTEMP  = 2'd2;
    localparam logic [1:0] REG_PRECHARGE = 2'd3;

    typedef enum logic [1:0] {
        MODE_LV        = 2'd0,
        MODE_PRECHARGE = 2'd1,
        MODE_TS        = 2'd2,
        MODE_RTD       = 2'd3
    } t_mode;

    typedef struct packed {
        logic                     tick;
        logic                     ts_button_n;
        logic                     rtd_button_n;
        logic                     cell_valid;
        logic                     cell_first;
        logic                     cell_last;
        logic [MV_W-1:0]          cell_mv;
        logic signed [TEMP_W-1:0] cell_temp_dc;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               car_mode;
        logic                     air_minus_closed;
        logic                     air_plus_closed;
        logic                     precharge_closed;
        logic                     report_valid;
        logic [MV_W-1:0]          min_cell_mv;
        logic [MV_W-1:0]          max_cell_mv;
        logic signed [TEMP_W-1:0] max_temp_dc;
        logic                     bms_fault;
    } t_out_item;

    typedef struct packed {
        logic [MV_W-1:0]          undervolt_mv;
        logic [MV_W-1:0]          overvolt_mv;
        logic signed [TEMP_W-1:0] overtemp_dc;
        logic [CNT_W-1:0]         precharge_ticks;
    } t_limits;

    typedef struct packed {
        logic fault;
        logic report;
    } t_scan_status;

    typedef struct packed {
        logic [MV_W-1:0]          min_mv;
        logic [MV_W-1:0]          max_mv;
        logic signed [TEMP_W-1:0] max_temp;
        logic                     fault;
    } t_pub;

endpackage

[hdl/hvps_in_if.sv]
// Input item channel: valid, ready and one sample period as payload.
`timescale 1ns / 1ps
interface hvps_in_if;
    import hvps_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/hvps_out_if.sv]
// Result item channel: valid, ready and the relay and BMS report payload.
`timescale 1ns / 1ps
interface hvps_out_if;
    import hvps_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/hvps_bms_scan.sv]
// BMS scan: running cell extremes, limit check and published report.
`timescale 1ns / 1ps
module hvps_bms_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  hvps_pkg::t_in_item    i_item,
    input  hvps_pkg::t_limits     i_lim,
    output hvps_pkg::t_scan_status o_status,
    output hvps_pkg::t_pub        o_pub
);
    import hvps_pkg::*;

    logic [MV_W-1:0]          r_run_min, n_run_min;
    logic [MV_W-1:0]          r_run_max, n_run_max;
    logic signed [TEMP_W-1:0] r_run_temp, n_run_temp;
    logic                     r_stopped, n_stopped;
    t_pub                     r_pub, n_pub;

    logic                     w_first;
    logic                     w_take;
    logic                     w_fault;
    logic                     w_publish;
    logic [MV_W-1:0]          w_base_min, w_base_max, w_new_min, w_new_max;
    logic signed [TEMP_W-1:0] w_base_temp, w_new_temp;

    always_comb begin
        w_first     = i_item.cell_valid && i_item.cell_first;
        w_base_min  = w_first ? RUN_MIN_RST  : r_run_min;
        w_base_max  = w_first ? RUN_MAX_RST  : r_run_max;
        w_base_temp = w_first ? RUN_TEMP_RST : r_run_temp;
        w_take      = i_item.cell_valid && (w_first || !r_stopped);

        w_new_min  = (i_item.cell_mv < w_base_min) ? i_item.cell_mv : w_base_min;
        w_new_max  = (i_item.cell_mv > w_base_max) ? i_item.cell_mv : w_base_max;
        w_new_temp = ($signed(i_item.cell_temp_dc) > $signed(w_base_temp)) ?
                     i_item.cell_temp_dc : w_base_temp;

        w_fault   = w_take && ((i_item.cell_mv < i_lim.undervolt_mv) ||
                               (i_item.cell_mv > i_lim.overvolt_mv) ||
                               ($signed(i_item.cell_temp_dc) > $signed(i_lim.overtemp_dc)));
        w_publish = w_take && (w_fault || i_item.cell_last);

        n_run_min  = w_take ? w_new_min  : r_run_min;
        n_run_max  = w_take ? w_new_max  : r_run_max;
        n_run_temp = w_take ? w_new_temp : r_run_temp;
        if (w_publish) begin
            n_stopped = 1'b1;
        end else if (w_first) begin
            n_stopped = 1'b0;
        end else begin
            n_stopped = r_stopped;
        end

        n_pub = r_pub;
        if (w_publish) begin
            n_pub.min_mv   = w_new_min;
            n_pub.max_mv   = w_new_max;
            n_pub.max_temp = w_new_temp;
            n_pub.fault    = w_fault;
        end

        o_status.fault  = w_fault;
        o_status.report = w_publish;
        o_pub           = n_pub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_min  <= RUN_MIN_RST;
            r_run_max  <= RUN_MAX_RST;
            r_run_temp <= RUN_TEMP_RST;
            r_stopped  <= 1'b0;
            r_pub      <= '0;
        end else if (i_step) begin
            r_run_min  <= n_run_min;
            r_run_max  <= n_run_max;
            r_run_temp <= n_run_temp;
            r_stopped  <= n_stopped;
            r_pub      <= n_pub;
        end
    end
endmodule

[hdl/hvps_mode_fsm.sv]
// Car mode state machine with precharge tick counter and fault override.
`timescale 1ns / 1ps
module hvps_mode_fsm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  hvps_pkg::t_in_item           i_item,
    input  logic [hvps_pkg::CNT_W-1:0]   i_precharge_ticks,
    input  hvps_pkg::t_scan_status       i_status,
    output hvps_pkg::t_mode              o_mode
);
    import hvps_pkg::*;

    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        case (r_mode)
            MODE_LV: begin
                if (!i_item.ts_button_n) begin
                    n_mode  = MODE_PRECHARGE;
                    n_count = '0;
                end
            end
            MODE_PRECHARGE: begin
                if (i_item.tick) begin
                    n_count = r_count + 1'b1;
                    if (n_count >= i_precharge_ticks) begin
                        n_mode = MODE_TS;
                    end
                end
            end
            MODE_TS: begin
                if (!i_item.rtd_button_n) begin
                    n_mode = MODE_RTD;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
        if (i_status.fault) begin
            n_mode  = MODE_LV;
            n_count = '0;
        end
        o_mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_LV;
            r_count <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end
endmodule

[hdl/hv_precharge_safety_sequencer.sv]
// Top level: APB limit registers, input and result registers, mode and BMS logic.
// One result per sample item, one item per clock when the result side keeps up. An item is
// held in the input register, passes one compare-and-select step through the mode state
// machine and the BMS scan, and lands in the result register. The result register parts the
// two channels, so a new item is taken while a finished result still waits. Limits are
// read and written over APB at byte addresses 0x0 (undervolt mV), 0x4 (overvolt mV),
// 0x8 (overtemp 0.1 C, signed) and 0xC (precharge ticks); write them only while no item
// is in flight.
`timescale 1ns / 1ps
`include "hv_precharge_safety_sequencer_defines.svh"
module hv_precharge_safety_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hvps_in_if.sink                       i_cell,
    hvps_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hvps_pkg::APB_AW-1:0]   paddr,
    input  logic [hvps_pkg::APB_DW-1:0]   pwdata,
    output logic [hvps_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import hvps_pkg::*;

    t_limits      r_lim;
    logic         r_in_valid;
    t_in_item     r_in;
    logic         r_out_valid;
    t_out_item    r_out, n_out;

    logic         w_step;
    logic         w_cfg_wr;
    logic [1:0]   w_reg_idx;
    t_mode        w_mode;
    t_scan_status w_status;
    t_pub         w_pub;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.undervolt_mv    <= UNDERVOLT_RST;
            r_lim.overvolt_mv     <= OVERVOLT_RST;
            r_lim.overtemp_dc     <= OVERTEMP_RST;
            r_lim.precharge_ticks <= PRECHARGE_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_UNDERVOLT: r_lim.undervolt_mv    <= pwdata[MV_W-1:0];
                REG_OVERVOLT:  r_lim.overvolt_mv     <= pwdata[MV_W-1:0];
                REG_OVERTEMP:  r_lim.overtemp_dc     <= pwdata[TEMP_W-1:0];
                REG_PRECHARGE: r_lim.precharge_ticks <= pwdata[CNT_W-1:0];
                default:       r_lim                 <= r_lim;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_UNDERVOLT: prdata = {{(APB_DW-MV_W){1'b0}}, r_lim.undervolt_mv};
            REG_OVERVOLT:  prdata = {{(APB_DW-MV_W){1'b0}}, r_lim.overvolt_mv};
            REG_OVERTEMP:  prdata = {{(APB_DW-TEMP_W){r_lim.overtemp_dc[TEMP_W-1]}},
                                     r_lim.overtemp_dc};
            REG_PRECHARGE: prdata = {{(APB_DW-CNT_W){1'b0}}, r_lim.precharge_ticks};
            default:       prdata = '0;
        endcase
    end

    // advance the held item into the result register when that slot is free or drains
    assign w_step       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cell.ready = !r_in_valid || w_step;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cell.ready) begin
            r_in_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cell.ready && i_cell.valid) begin
            r_in <= i_cell.data;
        end
    end

    hvps_bms_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in),
        .i_lim    (r_lim),
        .o_status (w_status),
        .o_pub    (w_pub)
    );

    hvps_mode_fsm u_fsm (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (w_step),
        .i_item            (r_in),
        .i_precharge_ticks (r_lim.precharge_ticks),
        .i_status          (w_status),
        .o_mode            (w_mode)
    );

    always_comb begin
        n_out.car_mode         = w_mode;
        n_out.air_minus_closed = (w_mode != MODE_LV);
        n_out.air_plus_closed  = (w_mode == MODE_TS) || (w_mode == MODE_RTD);
        n_out.precharge_closed = (w_mode == MODE_PRECHARGE);
        n_out.report_valid     = w_status.report;
        n_out.min_cell_mv      = w_pub.min_mv;
        n_out.max_cell_mv      = w_pub.max_mv;
        n_out.max_temp_dc      = w_pub.max_temp;
        n_out.bms_fault        = w_pub.fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= n_out;
        end
    end

    `HVPS_ASSERT(a_fault_forces_lv, i_clk, i_rst_n, (r_out_valid && r_out.report_valid && r_out.bms_fault) |-> (r_out.car_mode == MODE_LV), "published fault without LV mode")
    `HVPS_ASSERT(a_relay_exclusive, i_clk, i_rst_n, r_out_valid |-> !(r_out.precharge_closed && r_out.air_plus_closed) && (r_out.air_minus_closed || !r_out.air_plus_closed), "illegal relay combination")
    `HVPS_ASSERT(a_stall_only_full, i_clk, i_rst_n, !i_cell.ready |-> (r_in_valid && r_out_valid && !o_res.ready), "input stalled with free slot")
    `HVPS_ASSERT_ALWAYS(a_step_fills_out, i_clk, (i_rst_n && w_step) |=> r_out_valid, "result register not filled after step")

endmodule

[bench/hvps_sequencer_checker.sv]
// Checker for the HV precharge sequencer: mirrors mode and BMS scan, compares result beats.
`timescale 1ns / 1ps
module hvps_sequencer_checker
    import hvps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    hvps_in_if                i_cell_mon,
    hvps_out_if               i_res_mon,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                o_mismatches,
    output int                o_outstanding,
    output int                o_beats,
    output int                o_reports,
    output int                o_faults
);

    t_limits                  limits;
    t_mode                    mode;
    logic [CNT_W-1:0]         precharge_cnt;
    logic [MV_W-1:0]          run_min;
    logic [MV_W-1:0]          run_max;
    logic signed [TEMP_W-1:0] run_temp;
    logic                     scan_done;
    t_pub                     published;

    t_out_item                expected_beats[$];
    t_out_item                got;
    t_out_item                want;
    int                       errs;
    int                       beats;
    int                       reports;
    int                       faults;

    function automatic t_out_item predict_result(input t_in_item s);
        t_out_item        r;
        logic [CNT_W-1:0] next_cnt;
        logic             cell_bad;
        logic             published_now;
        published_now = 1'b0;
        case (mode)
            MODE_LV: begin
                if (!s.ts_button_n) begin
                    mode = MODE_PRECHARGE;
                    precharge_cnt = '0;
                end
            end
            MODE_PRECHARGE: begin
                if (s.tick) begin
                    next_cnt = precharge_cnt + 1'b1;
                    precharge_cnt = next_cnt;
                    if (next_cnt >= limits.precharge_ticks) mode = MODE_TS;
                end
            end
            MODE_TS: begin
                if (!s.rtd_button_n) mode = MODE_RTD;
            end
            default: ;
        endcase
        if (s.cell_valid) begin
            if (s.cell_first) begin
                run_min = RUN_MIN_RST;
                run_max = RUN_MAX_RST;
                run_temp = RUN_TEMP_RST;
                scan_done = 1'b0;
            end
            if (!scan_done) begin
                if (s.cell_mv < run_min) run_min = s.cell_mv;
                if (s.cell_mv > run_max) run_max = s.cell_mv;
                if (s.cell_temp_dc > run_temp) run_temp = s.cell_temp_dc;
                cell_bad = (s.cell_mv < limits.undervolt_mv) ||
                           (s.cell_mv > limits.overvolt_mv) ||
                           (s.cell_temp_dc > limits.overtemp_dc);
                if (cell_bad || s.cell_last) begin
                    published = '{run_min, run_max, run_temp, cell_bad};
                    published_now = 1'b1;
                    scan_done = 1'b1;
                end
                if (cell_bad) begin
                    mode = MODE_LV;
                    precharge_cnt = '0;
                end
            end
        end
        r.car_mode         = mode;
        r.air_minus_closed = (mode != MODE_LV);
        r.air_plus_closed  = (mode == MODE_TS) || (mode == MODE_RTD);
        r.precharge_closed = (mode == MODE_PRECHARGE);
        r.report_valid     = published_now;
        r.min_cell_mv      = published.min_mv;
        r.max_cell_mv      = published.max_mv;
        r.max_temp_dc      = published.max_temp;
        r.bms_fault        = published.fault;
        return r;
    endfunction

    function automatic string describe(input t_out_item r);
        return $sformatf("mode %0d air- %0b air+ %0b pre %0b rep %0b min %0d max %0d temp %0d flt %0b",
                         r.car_mode, r.air_minus_closed, r.air_plus_closed, r.precharge_closed,
                         r.report_valid, r.min_cell_mv, r.max_cell_mv, r.max_temp_dc,
                         r.bms_fault);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limits = '{UNDERVOLT_RST, OVERVOLT_RST, OVERTEMP_RST, PRECHARGE_RST};
            mode = MODE_LV;
            precharge_cnt = '0;
            run_min = RUN_MIN_RST;
            run_max = RUN_MAX_RST;
            run_temp = RUN_TEMP_RST;
            scan_done = 1'b0;
            published = '0;
            expected_beats.delete();
            errs = 0;
            beats = 0;
            reports = 0;
            faults = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_UNDERVOLT: limits.undervolt_mv = pwdata[MV_W-1:0];
                    REG_OVERVOLT:  limits.overvolt_mv = pwdata[MV_W-1:0];
                    REG_OVERTEMP:  limits.overtemp_dc = pwdata[TEMP_W-1:0];
                    REG_PRECHARGE: limits.precharge_ticks = pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cell_mon.valid && i_cell_mon.ready)
                expected_beats.push_back(predict_result(i_cell_mon.data));
            if (i_res_mon.valid && i_res_mon.ready) begin
                got = i_res_mon.data;
                beats++;
                if (got.report_valid) reports++;
                if (got.report_valid && got.bms_fault) faults++;
                if (expected_beats.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: result beat with nothing expected: %s",
                                 $realtime, describe(got));
                end else begin
                    want = expected_beats.pop_front();
                    if (got.car_mode !== want.car_mode ||
                        got.air_minus_closed !== want.air_minus_closed ||
                        got.air_plus_closed !== want.air_plus_closed ||
                        got.precharge_closed !== want.precharge_closed ||
                        got.report_valid !== want.report_valid ||
                        got.min_cell_mv !== want.min_cell_mv ||
                        got.max_cell_mv !== want.max_cell_mv ||
                        got.max_temp_dc !== want.max_temp_dc ||
                        got.bms_fault !== want.bms_fault) begin
                        errs++;
                        if (errs <= 10)
                            $display("%0t: beat %0d mismatch\n  expected %s\n  actual   %s",
                                     $realtime, beats, describe(want), describe(got));
                    end
                end
            end
        end
        o_mismatches  <= errs;
        o_outstanding <= expected_beats.size();
        o_beats       <= beats;
        o_reports     <= reports;
        o_faults      <= faults;
    end

endmodule

[bench/tb_hv_precharge_safety_sequencer.sv]
// Testbench top for the HV precharge sequencer: clock, reset, stimulus, limits and verdict.
`timescale 1ns / 1ps
module tb_hv_precharge_safety_sequencer;
    import hvps_pkg::*;

    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 181;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    hvps_in_if  cell_if ();
    hvps_out_if res_if ();

    int      mismatches;
    int      outstanding;
    int      beats;
    int      reports;
    int      faults;

    t_limits limits_now;
    bit      steady;
    int      scan_left;
    int      sent;
    int      settings_used;

    hv_precharge_safety_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hvps_sequencer_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cell_mon    (cell_if),
        .i_res_mon     (res_if),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_beats       (beats),
        .o_reports     (reports),
        .o_faults      (faults)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic t_in_item period_item(input bit tick, input bit ts_n, input bit rtd_n,
                                             input bit v, input bit f, input bit l,
                                             input int mv, input int temp);
        t_in_item s;
        s.tick         = tick;
        s.ts_button_n  = ts_n;
        s.rtd_button_n = rtd_n;
        s.cell_valid   = v;
        s.cell_first   = f;
        s.cell_last    = l;
        s.cell_mv      = mv[MV_W-1:0];
        s.cell_temp_dc = temp[TEMP_W-1:0];
        return s;
    endfunction

    task automatic send_period(input t_in_item s);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            cell_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cell_if.valid <= 1'b1;
        cell_if.data  <= s;
        @(posedge i_clk);
        while (!cell_if.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain_results();
        cell_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic apply_limits(input t_limits l);
        write_limit(REG_UNDERVOLT, APB_DW'(l.undervolt_mv));
        write_limit(REG_OVERVOLT, APB_DW'(l.overvolt_mv));
        write_limit(REG_OVERTEMP, {{(APB_DW-TEMP_W){l.overtemp_dc[TEMP_W-1]}}, l.overtemp_dc});
        write_limit(REG_PRECHARGE, APB_DW'(l.precharge_ticks));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limits_now = l;
        settings_used++;
    endtask

    task automatic pick_limits(input int p, output t_limits l);
        case (p)
            0: l = '{13'd2800, 13'd4300, 12'sd600, 16'd3};
            1: l = '{13'd0, 13'd8191, 12'sd2047, 16'd1};
            2: l = '{13'd3000, 13'd4000, -12'sd1000, 16'd7};
            3: l = '{13'd8191, 13'd0, -12'sd2048, 16'd2};
            5: l = '{13'd2800, 13'd4300, 12'sd600, 16'd65535};
            7: l = '{13'd3300, 13'd3900, 12'sd450, 16'd12};
            default: begin
                l.undervolt_mv    = MV_W'($urandom_range(2000, 3400));
                l.overvolt_mv     = MV_W'($urandom_range(3600, 5000));
                l.overtemp_dc     = TEMP_W'(int'($urandom_range(0, 3000)) - 1000);
                l.precharge_ticks = (p == 6) ? 16'd0 : 16'($urandom_range(1, 20));
            end
        endcase
    endtask

    task automatic next_period(output t_in_item s);
        int roll;
        int t;
        s = 31'($urandom);
        s.tick         = 1'($urandom_range(0, 1));
        s.ts_button_n  = ($urandom_range(0, 7) != 0);
        s.rtd_button_n = ($urandom_range(0, 5) != 0);
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
            s.cell_valid = 1'b1;
            s.cell_first = (scan_left == 0);
            if (scan_left == 0) scan_left = $urandom_range(1, 10);
            s.cell_last = (scan_left == 1);
            scan_left--;
            if ($urandom_range(0, 13) != 0) begin
                s.cell_mv = MV_W'($urandom_range(limits_now.undervolt_mv,
                                                 limits_now.overvolt_mv));
                t = int'(limits_now.overtemp_dc) - int'($urandom_range(0, 700));
                if (t < -2048) t = -2048;
                s.cell_temp_dc = t[TEMP_W-1:0];
            end
        end else if (roll < 9) begin
            s.cell_valid = 1'b0;
        end else begin
            s.cell_valid = 1'b1;
        end
    endtask

    initial begin
        int       stall;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    initial begin
        t_limits  l;
        t_in_item s;
        i_rst_n       <= 1'b0;
        cell_if.valid <= 1'b0;
        cell_if.data  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        steady        = 1'b0;
        scan_left     = 0;
        sent          = 0;
        settings_used = 1;
        limits_now    = '{UNDERVOLT_RST, OVERVOLT_RST, OVERTEMP_RST, PRECHARGE_RST};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_period(period_item(0, 1, 1, 1, 0, 0, 3000, 250));
        send_period(period_item(1, 1, 0, 0, 1, 1, 8191, 2047));
        send_period(period_item(0, 1, 1, 1, 0, 1, 4300, 600));
        send_period(period_item(0, 1, 1, 1, 0, 0, 0, -2048));
        send_period(period_item(0, 0, 1, 0, 0, 0, 0, 0));
        send_period(period_item(1, 0, 0, 0, 0, 0, 0, 0));
        send_period(period_item(1, 1, 1, 1, 1, 0, 2800, -1000));
        send_period(period_item(0, 1, 1, 1, 0, 0, 2799, 100));
        drain_results();
        apply_limits('{UNDERVOLT_RST, OVERVOLT_RST, OVERTEMP_RST, 16'd0});
        send_period(period_item(0, 0, 1, 0, 0, 0, 0, 0));
        send_period(period_item(0, 1, 1, 0, 0, 0, 0, 0));
        send_period(period_item(1, 1, 1, 0, 0, 0, 0, 0));
        send_period(period_item(0, 0, 0, 0, 0, 0, 0, 0));
        send_period(period_item(1, 0, 1, 1, 1, 1, 3700, 599));
        send_period(period_item(1, 1, 0, 1, 1, 0, 8191, 2047));
        send_period(period_item(0, 0, 1, 1, 1, 0, 3000, 601));
        send_period(period_item(0, 0, 1, 0, 0, 0, 0, 0));
        send_period(period_item(0, 1, 1, 1, 1, 0, 4301, 0));
        send_period(period_item(0, 0, 1, 0, 0, 0, 0, 0));
        send_period(period_item(1, 1, 1, 0, 0, 0, 0, 0));
        send_period(period_item(0, 1, 1, 1, 0, 0, 3500, 0));
        send_period(period_item(0, 1, 1, 1, 1, 1, 3500, -2048));

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            pick_limits(p, l);
            apply_limits(l);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 60 == 0) steady = ($urandom_range(0, 3) == 0);
                next_period(s);
                send_period(s);
            end
        end

        steady = 1'b0;
        drain_results();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d sample periods under %0d limit settings; %0d result beats checked.",
                 sent, settings_used, beats);
        $display("Scan reports seen: %0d, with a cell out of limits: %0d.", reports, faults);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_hv_precharge_safety_sequencer: PASS");
        end else begin
            $display("tb_hv_precharge_safety_sequencer: FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding.", outstanding);
        $display("tb_hv_precharge_safety_sequencer: FAIL");
        $finish;
    end

endmodule
